// File: design/gs_pkg.sv
`timescale 1ns / 1ps
package gs_pkg;
	localparam int MAX_SIZE_DEF  = 16;
	localparam int FRAC_BITS_DEF = 16;
	localparam logic [1:0] CMD_A     = 2'd0;
	localparam logic [1:0] CMD_B     = 2'd1;
	localparam logic [1:0] CMD_SOLVE = 2'd2;
	localparam logic [1:0] ST_CONV   = 2'd0;
	localparam logic [1:0] ST_LIMIT  = 2'd1;
	localparam logic [1:0] ST_ZDIAG  = 2'd2;
	localparam logic [1:0] REG_SIZE  = 2'd0;
	localparam logic [1:0] REG_TOL   = 2'd1;
	localparam logic [1:0] REG_ITER  = 2'd2;
endpackage

// File: design/gauss_seidel_solver.sv
`timescale 1ns / 1ps
// Gauss-Seidel solver, signed fixed point with FRAC_BITS fraction bits.
// Input stream s_axis: tdata {value, column, row} from bit 0 = row[3:0], column[7:4],
// value[39:8]; tuser = command. Commands 0/1 load A[row][col] / b[row], one item
// per cycle while idle. Command 2 starts a solve; s_axis_tready stays low until all
// results are taken.
// Output stream m_axis: one item per unknown, tdata = solution_value[31:0],
// solution_index[35:32], status[37:36], iterations_used[53:38]; tlast on the last.
// Solve sequence: accept, diagonal checks, then per sweep each row does a read and a
// multiply-accumulate per column on one shared registered 32x32 multiplier, a fetch of
// A_ii, a 66-step radix-2 divide and a write-back; the norm and stop test end the sweep.
// m_axis_tvalid drops after each accepted item before the next one is presented.
// Output stalls simply hold the current item; nothing is dropped.
// Reset clears the control state and restores size 16, tolerance 66, 100
// iterations. A and b contents are undefined until written.
// Config: cfg_we, cfg_index (0 size, 1 tolerance, 2 max iterations), cfg_data.
module gauss_seidel_solver import gs_pkg::*; #(
	parameter int MAX_SIZE  = MAX_SIZE_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [30:0] cfg_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // row, column, value
	input  logic [1:0]  s_axis_tuser,  // command
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [55:0] m_axis_tdata,  // solution_value, solution_index, status, iterations_used
	output logic        m_axis_tlast
);
	localparam int IW = $clog2(MAX_SIZE);
	// |num| < 2^(62-FRAC_BITS+IW), quotient carries FRAC_BITS more bits
	localparam int QB = 62 + IW;

	typedef enum logic [3:0] {
		IDLE, DCHK, ROWINIT, MREAD, MACC, DIVSET, DIV, DIVEND, NORM, NEXTIT, EMIT
	} state_t;

	state_t state_q;
	logic [31:0] a_mem [MAX_SIZE*MAX_SIZE];
	logic [31:0] b_mem [MAX_SIZE];
	logic [31:0] x_q [MAX_SIZE];
	logic [4:0]  size_q;
	logic [30:0] tol_q;
	logic [15:0] maxit_q, iter_q;
	logic [IW:0] n_q;
	logic [IW-1:0] i_q, j_q;
	logic signed [63:0] num_q;
	logic signed [31:0] arow_q;
	logic signed [63:0] prod_q;
	logic        pv_q;
	logic [63:0] rem_q, un_q;
	logic [31:0] ud_q;
	logic [QB-1:0] quo_q;
	logic [6:0]  cnt_q;
	logic        neg_q;
	logic [31:0] norm_q, prev_q;
	logic [1:0]  status_q;
	logic [31:0] dout_q;

	wire [3:0] in_row = s_axis_tdata[3:0];
	wire [3:0] in_col = s_axis_tdata[7:4];
	wire [31:0] in_val = s_axis_tdata[39:8];
	wire acc_in = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = (state_q == IDLE);

	logic [IW:0] n_eff;
	always_comb begin
		if (size_q == 5'd0) n_eff = (IW+1)'(1);
		else if (32'(size_q) > MAX_SIZE) n_eff = (IW+1)'(MAX_SIZE);
		else n_eff = (IW+1)'(size_q);
	end

	logic [IW-1:0] last_idx;
	assign last_idx = IW'(n_q - 1'b1);

	// memory writes from the input stream, registered reads
	always_ff @(posedge clk) begin
		if (acc_in && s_axis_tuser == CMD_A && 32'(in_row) < MAX_SIZE && 32'(in_col) < MAX_SIZE)
			a_mem[{IW'(in_row), IW'(in_col)}] <= in_val;
		if (acc_in && s_axis_tuser == CMD_B && 32'(in_row) < MAX_SIZE)
			b_mem[IW'(in_row)] <= in_val;
		arow_q <= a_mem[{i_q, j_q}];
	end

	wire [63:0] trial = {rem_q[62:0], un_q[63]};
	wire [31:0] xmag = x_q[j_q][31] ? 32'(-x_q[j_q]) : x_q[j_q];
	wire [31:0] ndiff = (norm_q >= prev_q) ? norm_q - prev_q : prev_q - norm_q;
	logic [31:0] sat;
	always_comb begin
		if (quo_q >= QB'(64'd1) << 31) sat = neg_q ? 32'h8000_0000 : 32'h7fff_ffff;
		else if (!neg_q) sat = (quo_q > QB'(32'h7fff_ffff)) ? 32'h7fff_ffff : quo_q[31:0];
		else sat = 32'(-quo_q[31:0]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			size_q <= 5'd16;
			tol_q <= 31'd66;
			maxit_q <= 16'd100;
			m_axis_tvalid <= 1'b0;
			pv_q <= 1'b0;
			cnt_q <= 7'd0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_SIZE: size_q <= cfg_data[4:0];
					REG_TOL:  tol_q <= cfg_data;
					REG_ITER: maxit_q <= cfg_data[15:0];
					default: ;
				endcase
			end
			unique case (state_q)
				IDLE: if (acc_in && s_axis_tuser == CMD_SOLVE) begin
					n_q <= n_eff;
					for (int k = 0; k < MAX_SIZE; k++) x_q[k] <= '0;
					prev_q <= '0;
					iter_q <= '0;
					status_q <= ST_LIMIT;
					i_q <= '0; j_q <= '0;
					state_q <= DCHK;
				end
				DCHK: begin
					// arow_q holds A[i][i] in the cycle after its address is set
					if (j_q != i_q) begin
						j_q <= i_q;
					end else if (cnt_q == 7'd0) begin
						cnt_q <= 7'd1;
					end else begin
						cnt_q <= 7'd0;
						if (arow_q == '0) begin
							status_q <= ST_ZDIAG;
							i_q <= '0;
							state_q <= EMIT;
						end else if (i_q == last_idx) begin
							i_q <= '0;
							if (maxit_q == '0) state_q <= EMIT;
							else state_q <= ROWINIT;
						end else begin
							i_q <= i_q + 1'b1;
							j_q <= i_q + 1'b1;
						end
					end
				end
				ROWINIT: begin
					num_q <= 64'(signed'(b_mem[i_q]));
					j_q <= '0;
					pv_q <= 1'b0;
					state_q <= MREAD;
				end
				// wait for the registered A read; marked count means the diagonal fetch for the divide
				MREAD: state_q <= (cnt_q == 7'd127) ? DIVSET : MACC;
				MACC: begin
					if (pv_q)
						num_q <= num_q - ((prod_q + (64'sd1 <<< (FRAC_BITS-1))) >>> FRAC_BITS);
					pv_q <= (j_q != i_q);
					prod_q <= arow_q * signed'(x_q[j_q]);
					if (32'(j_q) == 32'(n_q) - 1) state_q <= DIVSET;
					else begin
						j_q <= j_q + 1'b1;
						state_q <= MREAD;
					end
				end
				DIVSET: begin
					if (pv_q) begin
						num_q <= num_q - ((prod_q + (64'sd1 <<< (FRAC_BITS-1))) >>> FRAC_BITS);
						pv_q <= 1'b0;
						j_q <= i_q;
						state_q <= MREAD;
						cnt_q <= 7'd127;
					end else if (cnt_q != 7'd127 && j_q != i_q) begin
						j_q <= i_q;
						cnt_q <= 7'd127;
						state_q <= MREAD;
					end else begin
						// arow_q = A_ii
						neg_q <= num_q[63] ^ arow_q[31];
						un_q <= (num_q[63] ? 64'(-num_q) : 64'(num_q)) << (64 - QB + FRAC_BITS);
						ud_q <= arow_q[31] ? 32'(-arow_q) : arow_q;
						rem_q <= '0;
						quo_q <= '0;
						cnt_q <= 7'd0;
						state_q <= DIV;
					end
				end
				DIV: begin
					if (trial >= 64'(ud_q)) begin
						rem_q <= trial - 64'(ud_q);
						quo_q <= {quo_q[QB-2:0], 1'b1};
					end else begin
						rem_q <= trial;
						quo_q <= {quo_q[QB-2:0], 1'b0};
					end
					un_q <= un_q << 1;
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 7'(QB-1)) state_q <= DIVEND;
				end
				DIVEND: begin
					x_q[i_q] <= sat;
					cnt_q <= 7'd0;
					if (i_q == last_idx) begin
						j_q <= '0; norm_q <= '0;
						state_q <= NORM;
					end else begin
						i_q <= i_q + 1'b1;
						state_q <= ROWINIT;
					end
				end
				NORM: begin
					if (xmag > norm_q) norm_q <= xmag;
					if (j_q == last_idx) state_q <= NEXTIT;
					else j_q <= j_q + 1'b1;
				end
				NEXTIT: begin
					iter_q <= iter_q + 1'b1;
					i_q <= '0;
					if (ndiff < {1'b0, tol_q}) begin
						status_q <= ST_CONV;
						state_q <= EMIT;
					end else begin
						prev_q <= norm_q;
						if (iter_q + 1'b1 == maxit_q) state_q <= EMIT;
						else state_q <= ROWINIT;
					end
				end
				EMIT: begin
					if (!m_axis_tvalid) begin
						m_axis_tvalid <= 1'b1;
						dout_q <= x_q[i_q];
					end else if (m_axis_tready) begin
						m_axis_tvalid <= 1'b0;
						if (i_q == last_idx) state_q <= IDLE;
						else i_q <= i_q + 1'b1;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	assign m_axis_tdata = {2'b00, (status_q == ST_ZDIAG) ? 16'd0 : iter_q, status_q,
		4'(i_q), dout_q};
	assign m_axis_tlast = (i_q == last_idx);
endmodule

// File: tb/tb_gauss_seidel_solver.sv
`timescale 1ns / 1ps
module tb_gauss_seidel_solver;
	import gs_pkg::*;

	localparam logic [1:0] CMD_NONE = 2'd3;
	localparam int SZ = MAX_SIZE_DEF;
	localparam int FB = FRAC_BITS_DEF;

	typedef enum logic {OP_CFG, OP_LOAD} op_kind_t;

	typedef struct {
		op_kind_t    op;
		logic [1:0]  code;    // command, or register index for OP_CFG
		logic [3:0]  row;
		logic [3:0]  col;
		logic [31:0] val;
		bit          typed;   // expected status typed in: x all zero, no sweeps
		logic [1:0]  st;
		bit          squeeze; // receiver holds off on this solve
	} step_t;

	typedef struct packed {
		logic [31:0] value;
		logic [3:0]  index;
		logic        last;
		logic [1:0]  status;
		logic [15:0] iters;
	} solution_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [30:0] cfg_data = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata = '0;  // row, column, value
	logic [1:0]  s_axis_tuser = '0;  // command
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [55:0] m_axis_tdata;      // solution_value, solution_index, status, iterations_used
	logic        m_axis_tlast;

	gauss_seidel_solver i_dut (.*);

	always #2 clk = ~clk;

	// predictor state
	logic signed [31:0] coef_a [SZ][SZ];
	logic signed [31:0] rhs_b [SZ];
	logic signed [31:0] x_vec [SZ];
	logic [4:0]  size_reg = 5'd16;
	logic [30:0] tol_reg = 31'd66;
	logic [15:0] iter_reg = 16'd100;

	solution_t solution_q[$];
	int  mismatches = 0;
	bit  hold_req = 0;
	int  burst_left = 0;

	function automatic logic signed [31:0] fx_div(longint num, logic signed [31:0] den);
		bit neg;
		longint unsigned un, ud, qi, r, mag;
		neg = (num < 0) != (den < 0);
		un = (num < 0) ? longint'(-num) : num;
		ud = (den < 0) ? longint'(-longint'(den)) : longint'(den);
		qi = un / ud;
		r = un % ud;
		if (qi >= (64'd1 << (31 - FB)))
			mag = 64'h8000_0000;
		else
			mag = (qi << FB) + ((r << FB) / ud);
		if (!neg)
			return (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
		if (mag > 64'h8000_0000)
			mag = 64'h8000_0000;
		return 32'(64'd0 - mag);
	endfunction

	function automatic int active_size();
		if (size_reg == 0)
			return 1;
		return (size_reg > SZ) ? SZ : size_reg;
	endfunction

	// runs the sweeps and queues one solution item per unknown
	task automatic predict_solve(bit typed, logic [1:0] typed_st);
		int n;
		logic [1:0] st;
		int unsigned its;
		longint unsigned prev_norm, norm, diff, m;
		longint num, p;
		solution_t s;
		n = active_size();
		for (int i = 0; i < SZ; i++)
			x_vec[i] = 0;
		prev_norm = 0;
		st = ST_LIMIT;
		its = iter_reg;
		for (int i = 0; i < n; i++)
			if (coef_a[i][i] == 0) begin
				st = ST_ZDIAG;
				its = 0;
			end
		if (st != ST_ZDIAG)
			for (int k = 0; k < iter_reg; k++) begin
				for (int i = 0; i < n; i++) begin
					num = rhs_b[i];
					for (int j = 0; j < n; j++)
						if (j != i) begin
							p = longint'(coef_a[i][j]) * longint'(x_vec[j]);
							num -= (p + (64'sd1 <<< (FB - 1))) >>> FB;
						end
					x_vec[i] = fx_div(num, coef_a[i][i]);
				end
				norm = 0;
				for (int i = 0; i < n; i++) begin
					m = (x_vec[i] < 0) ? -longint'(x_vec[i]) : longint'(x_vec[i]);
					if (m > norm)
						norm = m;
				end
				diff = (norm >= prev_norm) ? norm - prev_norm : prev_norm - norm;
				if (diff < tol_reg) begin
					st = ST_CONV;
					its = k + 1;
					break;
				end
				prev_norm = norm;
			end
		for (int i = 0; i < n; i++) begin
			s.value = typed ? 32'd0 : x_vec[i];
			s.index = i[3:0];
			s.last = (i == n - 1);
			s.status = typed ? typed_st : st;
			s.iters = typed ? 16'd0 : its[15:0];
			solution_q.push_back(s);
		end
	endtask

	task automatic send_item(logic [1:0] cmd, logic [3:0] row, logic [3:0] col,
			logic [31:0] val, bit typed = 0, logic [1:0] st = ST_CONV);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			if ($urandom_range(0, 2) != 0) begin
				s_axis_tvalid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= cmd;
		s_axis_tdata <= {val, col, row};
		do @(posedge clk); while (!s_axis_tready);
		case (cmd)
			CMD_A: coef_a[row][col] = val;
			CMD_B: rhs_b[row] = val;
			CMD_SOLVE: predict_solve(typed, st);
			default: ;
		endcase
	endtask

	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		burst_left = 0;
		do @(posedge clk); while (solution_q.size() != 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [30:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_SIZE: size_reg = data[4:0];
			REG_TOL:  tol_reg = data;
			REG_ITER: iter_reg = data[15:0];
			default: ;
		endcase
	endtask

	function automatic logic [31:0] rand_val(bit wild);
		if (wild)
			return $urandom;
		return $urandom_range(0, 131072) - 65536;
	endfunction

	// random system of size n: mostly diagonally dominant, some wild or with a zero diagonal
	task automatic load_system(int n);
		int flavor;
		logic [31:0] d;
		flavor = $urandom_range(0, 9);
		for (int i = 0; i < n; i++) begin
			for (int j = 0; j < n; j++) begin
				if (i == j) begin
					d = (flavor >= 8) ? $urandom : $urandom_range(n * 2, n * 8) << FB;
					if (flavor < 8 && $urandom_range(0, 1))
						d = -d;
					if (flavor == 7 && i == n - 1)
						d = 0;
					send_item(CMD_A, 4'(i), 4'(j), d);
				end else
					send_item(CMD_A, 4'(i), 4'(j), rand_val(flavor >= 8));
				if ($urandom_range(0, 15) == 0)
					send_item(CMD_NONE, 4'($urandom), 4'($urandom), $urandom);
			end
			send_item(CMD_B, 4'(i), 4'($urandom),
				(flavor >= 8) ? $urandom : $urandom_range(0, 2 << 20) - (1 << 20));
		end
	endtask

	step_t plan[] = '{
		'{OP_CFG,  REG_SIZE,  0, 0, 32'd0,         0, ST_CONV,  0},
		'{OP_CFG,  REG_ITER,  0, 0, 32'd0,         0, ST_CONV,  0},
		'{OP_CFG,  REG_TOL,   0, 0, 32'd0,         0, ST_CONV,  0},
		'{OP_LOAD, CMD_A,     0, 0, 32'h7FFF_FFFF, 0, ST_CONV,  0},
		'{OP_LOAD, CMD_SOLVE, 0, 0, 32'd0,         1, ST_LIMIT, 0},
		'{OP_LOAD, CMD_A,     0, 0, 32'd0,         0, ST_CONV,  0},
		'{OP_LOAD, CMD_SOLVE, 0, 0, 32'd0,         1, ST_ZDIAG, 0},
		'{OP_CFG,  REG_ITER,  0, 0, 32'd5,         0, ST_CONV,  0},
		'{OP_CFG,  2'd3,      0, 0, 32'h7FFF_FFFF, 0, ST_CONV,  0},
		'{OP_LOAD, CMD_SOLVE, 0, 0, 32'd0,         1, ST_ZDIAG, 0},
		'{OP_LOAD, CMD_A,     0, 0, 32'h8000_0000, 0, ST_CONV,  0},
		'{OP_LOAD, CMD_B,     0, 0, 32'h7FFF_FFFF, 0, ST_CONV,  0},
		'{OP_LOAD, CMD_SOLVE, 0, 0, 32'd0,         0, ST_CONV,  0},
		'{OP_LOAD, CMD_A,     0, 0, 32'd1,         0, ST_CONV,  0},
		'{OP_LOAD, CMD_B,     0, 9, 32'h8000_0000, 0, ST_CONV,  0},
		'{OP_LOAD, CMD_SOLVE, 0, 0, 32'd0,         0, ST_CONV,  0},
		'{OP_CFG,  REG_SIZE,  0, 0, 32'd2,         0, ST_CONV,  0},
		'{OP_CFG,  REG_TOL,   0, 0, 32'h7FFF_FFFF, 0, ST_CONV,  0},
		'{OP_CFG,  REG_ITER,  0, 0, 32'hFFFF,      0, ST_CONV,  0},
		'{OP_LOAD, CMD_A,     0, 0, 32'h0004_0000, 0, ST_CONV,  0},
		'{OP_LOAD, CMD_A,     0, 1, 32'h0000_8000, 0, ST_CONV,  0},
		'{OP_LOAD, CMD_A,     1, 0, 32'hFFFF_0000, 0, ST_CONV,  0},
		'{OP_LOAD, CMD_A,     1, 1, 32'h0002_0000, 0, ST_CONV,  0},
		'{OP_LOAD, CMD_B,     1, 0, 32'hFFFF_0000, 0, ST_CONV,  0},
		'{OP_LOAD, CMD_NONE, 15, 15, 32'hFFFF_FFFF, 0, ST_CONV, 0},
		'{OP_LOAD, CMD_A,    15, 15, 32'h1234_5678, 0, ST_CONV, 0},
		'{OP_LOAD, CMD_SOLVE, 0, 0, 32'd0,         0, ST_CONV,  1},
		'{OP_LOAD, CMD_B,     0, 0, 32'h0003_0000, 0, ST_CONV,  0},
		'{OP_LOAD, CMD_SOLVE, 0, 0, 32'd0,         0, ST_CONV,  0}
	};

	initial begin
		int n;
		int sent;
		logic [4:0] sz;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		foreach (plan[k]) begin
			if (plan[k].op == OP_CFG) begin
				wait_idle();
				write_reg(plan[k].code, plan[k].val[30:0]);
			end else begin
				if (plan[k].squeeze)
					hold_req = 1;
				send_item(plan[k].code, plan[k].row, plan[k].col, plan[k].val,
					plan[k].typed, plan[k].st);
			end
		end
		// every diagonal at full size, no sweeps allowed
		wait_idle();
		write_reg(REG_SIZE, 31'($urandom_range(16, 31)));
		write_reg(REG_ITER, 0);
		for (int i = 0; i < SZ; i++)
			send_item(CMD_A, 4'(i), 4'(i),
				(i == 15 && $urandom_range(0, 1)) ? 32'd0 : $urandom | 1);
		send_item(CMD_SOLVE, 0, 0, 0);
		sent = 0;
		while (sent < 125) begin
			wait_idle();
			sz = ($urandom_range(0, 5) == 0) ? 5'($urandom_range(0, 6)) : 5'($urandom_range(1, 4));
			write_reg(REG_SIZE, sz);
			if ($urandom_range(0, 5) == 0) begin
				write_reg(REG_TOL, 31'(31'h7FFF_FFFF - $urandom_range(0, 3)));
				write_reg(REG_ITER, 16'hFFFF);
			end else begin
				write_reg(REG_TOL,
					31'($urandom_range(0, 3) == 0 ? 31'd0 : $urandom_range(1, 4000)));
				write_reg(REG_ITER, 31'($urandom_range(0, 25)));
			end
			n = active_size();
			load_system(n);
			send_item(CMD_SOLVE, 4'($urandom), 4'($urandom), $urandom);
			sent += n * n + n + 1;
			if ($urandom_range(0, 1)) begin
				send_item(CMD_B, 4'($urandom_range(0, n - 1)), 0, rand_val(0));
				send_item(CMD_SOLVE, 0, 0, 0);
				sent += 2;
			end
		end
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (solution_q.size() != 0);
		repeat (50) @(posedge clk);
		if (mismatches == 0 && solution_q.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// output side: random stalls, calm stretches, one long hold-off
	int  hold_cnt = 0;
	bit  calm = 0;
	always @(posedge clk) begin
		solution_t e;
		solution_t got;
		if (m_axis_tvalid && m_axis_tready) begin
			got.value = m_axis_tdata[31:0];
			got.index = m_axis_tdata[35:32];
			got.status = m_axis_tdata[37:36];
			got.iters = m_axis_tdata[53:38];
			got.last = m_axis_tlast;
			if (solution_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected item: value %h index %0d", got.value, got.index);
			end else begin
				e = solution_q.pop_front();
				if (got != e) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp val %h idx %0d last %b st %0d it %0d / got val %h idx %0d last %b st %0d it %0d",
							e.value, e.index, e.last, e.status, e.iters,
							got.value, got.index, got.last, got.status, got.iters);
				end
			end
		end
		if (hold_req && m_axis_tvalid && hold_cnt == 0) begin
			hold_req = 0;
			hold_cnt = 400;
		end
		if ($urandom_range(0, 63) == 0)
			calm = ~calm;
		if (hold_cnt > 0) begin
			hold_cnt--;
			m_axis_tready <= 1'b0;
		end else
			m_axis_tready <= calm || ($urandom_range(0, 3) != 0);
	end

	initial begin
		#8ms;
		$display("== FAIL ==");
		$finish;
	end
endmodule
